// ----- rtl/mcfvs_pkg.sv -----
// Package with shared types, constants and helpers of the MIDI channel filter and velocity scaler.
package mcfvs_pkg;

  localparam int NumChannels = 16;
  localparam int ChanW       = 4;
  localparam int CfgW        = 16;
  localparam int GainW       = 12;
  localparam int AccW        = 33;
  localparam int MulAW       = 26;
  localparam int MulBW       = 22;
  localparam int MulPW       = MulAW + MulBW;

  localparam logic [3:0] CmdNoteOff = 4'h8;
  localparam logic [3:0] CmdNoteOn  = 4'h9;
  localparam logic [3:0] CmdCc      = 4'hB;

  localparam logic [6:0] CcVolume     = 7'd7;
  localparam logic [6:0] CcExpression = 7'd11;
  localparam logic [6:0] VelMax       = 7'd127;
  localparam logic [6:0] VelMin       = 7'd1;

  localparam logic [CfgW-1:0]  MaskReset  = 16'hFFFF;
  localparam logic [GainW-1:0] GainReset  = 12'd256;

  // Reciprocal of 127 * 127 scaled by 2^35; exact for dividends below 2^21.
  localparam logic [MulBW-1:0] RecipMul   = 22'd2130309;
  // Dividends at or above 128 * 16129 always saturate to the top velocity.
  localparam logic [24:0]      SatLimit   = 25'd2064512;

  typedef enum logic [1:0] {
    CFG_CHANNEL_MASK = 2'd0,
    CFG_APPLY_VOLUME = 2'd1,
    CFG_GAIN         = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_VOL,
    ST_EXPR,
    ST_DIV,
    ST_SHIFT,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_GAIN,
    STEP_VOL,
    STEP_EXPR,
    STEP_DIV,
    STEP_SHIFT
  } step_t;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] data1;
    logic [6:0] data2;
  } in_item_t;

  typedef struct packed {
    logic       forwarded;
    logic [7:0] out_status;
    logic [6:0] out_data1;
    logic [6:0] out_data2;
    logic       key_down;
    logic       key_up;
  } out_item_t;

  typedef struct packed {
    logic  capture;
    step_t step;
    logic  load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic scale;
    logic use_vol;
  } dp_stat_t;

  function automatic logic [6:0] sat_vel(input logic [10:0] v);
    logic [6:0] r;
    if (v > 11'(VelMax)) begin
      r = VelMax;
    end else if (v == 11'd0) begin
      r = VelMin;
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/midi_channel_filter_velocity_scaler_unit.sv -----
// Top level of the MIDI channel filter and velocity scaler.
//
// One MIDI channel message enters per in_data transaction and exactly one
// result leaves per out_data transaction, in the same order.
// Control changes 7 and 11 update the channel's volume and expression even
// when the channel is muted; a muted channel gives forwarded low.
// A forwarded note-on with nonzero velocity is scaled on a shared multiplier
// by gain, and by volume and expression if enabled, then clamped to 1..127.
// From acceptance, a message that is not scaled goes straight to the finish
// state; a note-on with volume scaling off passes through the gain and shift
// states, and with volume scaling on through the gain, volume, expression and
// reciprocal divide steps on the shared multiplier. A new message is taken in
// the cycle after the previous result is loaded; the block takes no new
// message before it is through with the last one.
// The result sits in an output register; while the receiver stalls, the
// block finishes the next message and waits with it in its finish state.
// Configuration is written via cfg_we, cfg_index and cfg_wdata, by the user
// only while idle (the block does not enforce it). Synchronous reset restores
// mask all ones, volume scaling on, unity gain, volumes and expressions 127.
module midi_channel_filter_velocity_scaler_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mcfvs_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mcfvs_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_wdata
);
  import mcfvs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mcfvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mcfvs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/mcfvs_dp.sv -----
// Datapath: configuration, channel tables, shared multiplier and the result register.
module mcfvs_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mcfvs_pkg::in_item_t in_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  mcfvs_pkg::dp_cmd_t  cmd,
  output mcfvs_pkg::dp_stat_t stat,
  output mcfvs_pkg::out_item_t out_data
);
  import mcfvs_pkg::*;

  logic [CfgW-1:0]  mask_r;
  logic             apply_vol_r;
  logic [GainW-1:0] gain_r;
  logic [6:0]       vol_r  [NumChannels];
  logic [6:0]       expr_r [NumChannels];
  in_item_t         item_r;
  logic             fwd_r;
  logic             scale_r;
  logic [AccW-1:0]  acc_r;
  logic [6:0]       vel_r;
  out_item_t        out_r;

  logic [ChanW-1:0] in_ch;
  logic [3:0]       in_cmd;
  logic             in_fwd;
  logic             in_scale;
  logic [ChanW-1:0] ch_r;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] mul_p;
  logic             div_big;
  logic [6:0]       div_q;

  assign in_ch    = in_data.status[3:0];
  assign in_cmd   = in_data.status[7:4];
  assign in_fwd   = mask_r[in_ch];
  assign in_scale = in_fwd && (in_cmd == CmdNoteOn) && (in_data.data2 != 7'd0);
  assign ch_r     = item_r.status[3:0];

  assign stat.scale   = in_scale;
  assign stat.use_vol = apply_vol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= MaskReset;
      apply_vol_r <= 1'b1;
      gain_r      <= GainReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL_MASK: mask_r      <= cfg_wdata;
        CFG_APPLY_VOLUME: apply_vol_r <= cfg_wdata[0];
        CFG_GAIN:         gain_r      <= cfg_wdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumChannels; i++) begin
        vol_r[i]  <= VelMax;
        expr_r[i] <= VelMax;
      end
    end else if (cmd.capture && (in_cmd == CmdCc)) begin
      if (in_data.data1 == CcVolume) begin
        vol_r[in_ch] <= in_data.data2;
      end
      if (in_data.data1 == CcExpression) begin
        expr_r[in_ch] <= in_data.data2;
      end
    end
  end

  always_comb begin
    unique case (cmd.step)
      STEP_GAIN: begin
        mul_a = {19'd0, item_r.data2};
        mul_b = {10'd0, gain_r};
      end
      STEP_VOL: begin
        mul_a = acc_r[MulAW-1:0];
        mul_b = {15'd0, vol_r[ch_r]};
      end
      STEP_EXPR: begin
        mul_a = acc_r[MulAW-1:0];
        mul_b = {15'd0, expr_r[ch_r]};
      end
      STEP_DIV: begin
        mul_a = {5'd0, acc_r[28:8]};
        mul_b = RecipMul;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = MulPW'(mul_a) * MulPW'(mul_b);
  assign div_big = acc_r[32:8] >= SatLimit;
  assign div_q   = mul_p[41:35];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r  <= in_data;
      fwd_r   <= in_fwd;
      scale_r <= in_scale;
    end
    unique case (cmd.step)
      STEP_GAIN, STEP_VOL, STEP_EXPR: acc_r <= mul_p[AccW-1:0];
      STEP_DIV:   vel_r <= sat_vel(div_big ? 11'(VelMax) : {4'd0, div_q});
      STEP_SHIFT: vel_r <= sat_vel(acc_r[18:8]);
      default: ;
    endcase
    if (cmd.load_out) begin
      out_r.forwarded  <= fwd_r;
      out_r.out_status <= item_r.status;
      out_r.out_data1  <= item_r.data1;
      out_r.out_data2  <= scale_r ? vel_r : item_r.data2;
      out_r.key_down   <= scale_r;
      out_r.key_up     <= fwd_r && (item_r.status[7:4] == CmdNoteOff);
    end
  end

  assign out_data = out_r;

  a_vel_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.step == STEP_DIV) |-> (vel_r != 7'd0))
    else $error("scaled velocity fell below one");

  a_key_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.load_out) |-> !(out_r.key_down && out_r.key_up))
    else $error("key_down and key_up raised together");

  a_key_needs_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.load_out) && (out_r.key_down || out_r.key_up) |-> out_r.forwarded)
    else $error("key event on a muted channel");

endmodule

// ----- rtl/mcfvs_ctrl.sv -----
// Controller state machine that sequences the datapath and owns the result valid flag.
module mcfvs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mcfvs_pkg::dp_stat_t stat,
  output mcfvs_pkg::dp_cmd_t  cmd
);
  import mcfvs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.scale ? ST_GAIN : ST_FIN;
        end
      end
      ST_GAIN:  state_nxt = stat.use_vol ? ST_VOL : ST_SHIFT;
      ST_VOL:   state_nxt = ST_EXPR;
      ST_EXPR:  state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_FIN;
      ST_SHIFT: state_nxt = ST_FIN;
      ST_FIN: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.step     = STEP_NONE;
    cmd.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_GAIN:  cmd.step = STEP_GAIN;
      ST_VOL:   cmd.step = STEP_VOL;
      ST_EXPR:  cmd.step = STEP_EXPR;
      ST_DIV:   cmd.step = STEP_DIV;
      ST_SHIFT: cmd.step = STEP_SHIFT;
      ST_FIN:   cmd.load_out = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while still held");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("controller stayed idle after a transaction");

  a_expr_then_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXPR) |=> (state_r == ST_DIV))
    else $error("expression product not followed by the divide step");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result became valid outside the finish state");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the MIDI channel filter and velocity scaler unit.
module tb;
  import mcfvs_pkg::*;

  localparam int CycleLimit    = 500000;
  localparam int RandPhases    = 9;
  localparam int ItemsPerPhase = 170;
  localparam int SettleCycles  = 8;
  localparam int GainFracBits  = 8;

  typedef enum logic {
    ROW_MSG,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_idx_t    idx;
    logic [15:0] val;
    in_item_t    msg;
    logic        has_exp;
    out_item_t   res;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  logic [15:0] mask_cfg;
  logic        vol_on_cfg;
  logic [11:0] gain_cfg;
  logic [6:0]  chan_vol [NumChannels];
  logic [6:0]  chan_expr [NumChannels];
  out_item_t   midi_out_q [$];
  stim_row_t   dir_tab [$];
  int          send_idle_pct = 12;
  int          recv_idle_pct = 68;
  int          mismatches = 0;
  int          cycles = 0;

  midi_channel_filter_velocity_scaler_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic out_item_t filter_and_scale(in_item_t m);
    logic [3:0]      cmd;
    logic [3:0]      ch;
    longint unsigned num;
    longint unsigned den;
    longint unsigned vel;
    out_item_t       r;
    cmd = m.status[7:4];
    ch  = m.status[3:0];
    if (cmd == CmdCc && m.data1 == CcVolume) begin
      chan_vol[ch] = m.data2;
    end
    if (cmd == CmdCc && m.data1 == CcExpression) begin
      chan_expr[ch] = m.data2;
    end
    r.forwarded  = mask_cfg[ch];
    r.out_status = m.status;
    r.out_data1  = m.data1;
    r.out_data2  = m.data2;
    r.key_down   = 1'b0;
    r.key_up     = 1'b0;
    if (r.forwarded && cmd == CmdNoteOn && m.data2 != 7'd0) begin
      num = 64'(m.data2) * 64'(gain_cfg);
      den = 64'd1 << GainFracBits;
      if (vol_on_cfg) begin
        num = num * 64'(chan_vol[ch]) * 64'(chan_expr[ch]);
        den = den * 64'(VelMax) * 64'(VelMax);
      end
      vel = num / den;
      if (vel > 64'(VelMax)) begin
        vel = 64'(VelMax);
      end
      if (vel < 64'(VelMin)) begin
        vel = 64'(VelMin);
      end
      r.out_data2 = vel[6:0];
      r.key_down  = 1'b1;
    end else if (r.forwarded && cmd == CmdNoteOff) begin
      r.key_up = 1'b1;
    end
    return r;
  endfunction

  function automatic in_item_t rand_midi_msg();
    in_item_t    m;
    int unsigned sel;
    int unsigned pick;
    logic [3:0]  ch;
    sel     = $urandom_range(99);
    pick    = $urandom_range(9);
    ch      = 4'($urandom_range(15));
    m.data1 = 7'($urandom_range(127));
    m.data2 = 7'($urandom_range(127));
    if (sel < 40) begin
      m.status = {CmdNoteOn, ch};
      if (pick == 0) begin
        m.data2 = 7'd0;
      end
    end else if (sel < 55) begin
      m.status = {CmdNoteOff, ch};
    end else if (sel < 80) begin
      m.status = {CmdCc, ch};
      if (pick < 4) begin
        m.data1 = CcVolume;
      end else if (pick < 8) begin
        m.data1 = CcExpression;
      end
      if ($urandom_range(3) == 0) begin
        m.data2 = 7'($urandom_range(8));
      end
    end else begin
      m.status = 8'($urandom_range(255));
    end
    return m;
  endfunction

  function automatic stim_row_t msg_row(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
    stim_row_t r;
    r            = '0;
    r.kind       = ROW_MSG;
    r.msg.status = st;
    r.msg.data1  = d1;
    r.msg.data2  = d2;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
                                          logic fwd, logic [6:0] od2, logic kd, logic ku);
    stim_row_t r;
    r                = msg_row(st, d1, d2);
    r.has_exp        = 1'b1;
    r.res.forwarded  = fwd;
    r.res.out_status = st;
    r.res.out_data1  = d1;
    r.res.out_data2  = od2;
    r.res.key_down   = kd;
    r.res.key_up     = ku;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(cfg_idx_t idx, logic [15:0] val);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  function automatic void tab_add(stim_row_t r);
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    in_valid <= 1'b0;
    while (midi_out_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CHANNEL_MASK: begin
        mask_cfg = val;
      end
      CFG_APPLY_VOLUME: begin
        vol_on_cfg = val[0];
      end
      CFG_GAIN: begin
        gain_cfg = val[11:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_msg(in_item_t m, logic has_exp, out_item_t known_res);
    out_item_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pred = filter_and_scale(m);
    if (has_exp) begin
      pred = known_res;
    end
    midi_out_q.insert(midi_out_q.size(), pred);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("midi_channel_filter_velocity_scaler_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (midi_out_q.size() == 0) begin
          $error("unexpected transaction: status %0h data1 %0d data2 %0d",
                 out_data.out_status, out_data.out_data1, out_data.out_data2);
          mismatches++;
        end else begin
          want = midi_out_q.pop_front();
          check_field("forwarded", want.forwarded, out_data.forwarded);
          check_field("out_status", want.out_status, out_data.out_status);
          check_field("out_data1", want.out_data1, out_data.out_data1);
          check_field("out_data2", want.out_data2, out_data.out_data2);
          check_field("key_down", want.key_down, out_data.key_down);
          check_field("key_up", want.key_up, out_data.key_up);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    stim_row_t   row;
    logic [15:0] mask_v;
    logic [15:0] gain_v;
    logic        vol_v;
    mask_cfg   = MaskReset;
    vol_on_cfg = 1'b1;
    gain_cfg   = GainReset;
    for (int c = 0; c < NumChannels; c++) begin
      chan_vol[c]  = VelMax;
      chan_expr[c] = VelMax;
    end

    tab_add(known_row(8'h90, 7'd0, 7'd127, 1'b1, 7'd127, 1'b1, 1'b0));
    tab_add(known_row(8'h9F, 7'd127, 7'd1, 1'b1, 7'd1, 1'b1, 1'b0));
    tab_add(known_row(8'h95, 7'd60, 7'd0, 1'b1, 7'd0, 1'b0, 1'b0));
    tab_add(known_row(8'h83, 7'd60, 7'd64, 1'b1, 7'd64, 1'b0, 1'b1));
    tab_add(known_row(8'hB2, CcVolume, 7'd0, 1'b1, 7'd0, 1'b0, 1'b0));
    tab_add(known_row(8'h92, 7'd64, 7'd100, 1'b1, 7'd1, 1'b1, 1'b0));
    tab_add(msg_row(8'hB2, CcVolume, 7'd64));
    tab_add(msg_row(8'hB2, CcExpression, 7'd32));
    tab_add(msg_row(8'h92, 7'd64, 7'd127));
    tab_add(known_row(8'hF8, 7'd0, 7'd0, 1'b1, 7'd0, 1'b0, 1'b0));
    tab_add(known_row(8'hFF, 7'd127, 7'd127, 1'b1, 7'd127, 1'b0, 1'b0));
    tab_add(known_row(8'hA4, 7'd10, 7'd20, 1'b1, 7'd20, 1'b0, 1'b0));
    tab_add(known_row(8'hB0, 7'd1, 7'd99, 1'b1, 7'd99, 1'b0, 1'b0));
    tab_add(known_row(8'h00, 7'd0, 7'd0, 1'b1, 7'd0, 1'b0, 1'b0));
    tab_add(cfg_row(CFG_CHANNEL_MASK, 16'hFFFE));
    tab_add(known_row(8'hB0, CcVolume, 7'd10, 1'b0, 7'd10, 1'b0, 1'b0));
    tab_add(known_row(8'h90, 7'd60, 7'd100, 1'b0, 7'd100, 1'b0, 1'b0));
    tab_add(known_row(8'h80, 7'd60, 7'd0, 1'b0, 7'd0, 1'b0, 1'b0));
    tab_add(cfg_row(CFG_CHANNEL_MASK, 16'hFFFF));
    tab_add(msg_row(8'h90, 7'd60, 7'd127));
    tab_add(cfg_row(CFG_GAIN, 16'd0));
    tab_add(known_row(8'h91, 7'd60, 7'd127, 1'b1, 7'd1, 1'b1, 1'b0));
    tab_add(cfg_row(CFG_APPLY_VOLUME, 16'd0));
    tab_add(cfg_row(CFG_GAIN, 16'd4095));
    tab_add(known_row(8'h92, 7'd60, 7'd127, 1'b1, 7'd127, 1'b1, 1'b0));
    tab_add(known_row(8'h92, 7'd60, 7'd1, 1'b1, 7'd15, 1'b1, 1'b0));
    tab_add(cfg_row(CFG_GAIN, 16'd128));
    tab_add(known_row(8'h93, 7'd60, 7'd1, 1'b1, 7'd1, 1'b1, 1'b0));
    tab_add(known_row(8'h93, 7'd60, 7'd127, 1'b1, 7'd63, 1'b1, 1'b0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.idx, row.val);
      end else begin
        send_msg(row.msg, row.has_exp, row.res);
      end
    end

    for (int p = 0; p < RandPhases; p++) begin
      if (p == 3) begin
        send_idle_pct = 68;
        recv_idle_pct = 12;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      mask_v = 16'($urandom_range(65535));
      gain_v = 16'($urandom_range(4095));
      vol_v  = 1'b1;
      case (p)
        0: begin
          mask_v = 16'hFFFF;
          gain_v = 16'(GainReset);
        end
        1: begin
          vol_v  = 1'b0;
          gain_v = 16'd4095;
        end
        2: begin
          mask_v = 16'h0000;
        end
        3: begin
          gain_v = 16'd0;
        end
        4: begin
          mask_v = 16'hFFFF;
          vol_v  = 1'b0;
        end
        5: begin
          gain_v = 16'd4095;
        end
        6: begin
          vol_v  = 1'b0;
          gain_v = 16'd0;
        end
        7: begin
          mask_v = 16'hFFFF;
          gain_v = 16'($urandom_range(511));
        end
        default: begin
          gain_v = 16'(GainReset);
        end
      endcase
      write_reg(CFG_CHANNEL_MASK, mask_v);
      write_reg(CFG_APPLY_VOLUME, {15'd0, vol_v});
      write_reg(CFG_GAIN, gain_v);
      repeat (ItemsPerPhase) send_msg(rand_midi_msg(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (midi_out_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("midi_channel_filter_velocity_scaler_unit verification clean");
    end else begin
      $display("midi_channel_filter_velocity_scaler_unit verification failed");
    end
    $finish;
  end

endmodule
